/* hw/rtl/sdsched_pkg.sv */
package sdsched_pkg;

   // Request store geometry
   localparam int MAX_REQUESTS = 32;
   localparam int ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
   localparam int VIS_W        = $clog2(MAX_REQUESTS + 2);

   // Field widths
   localparam int TRACK_W = 16;
   localparam int SEEK_W  = 17;
   localparam int DISK_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_RIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_TRACKS = 2'd2;

   // Request codes
   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_RUN = 1'b1;

   // Controller states
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INS     = 6'b000010,
      ST_INS_PUT = 6'b000100,
      ST_SCAN    = 6'b001000,
      ST_SETUP   = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

endpackage

/* hw/rtl/scan_disk_scheduler_core.sv */
// Channel    Direction  Handshake               Payload
// req_       in         req_valid / req_ready   req_type, req_track
// rsp_       out        rsp_valid / rsp_ready   rsp_served_track, rsp_seek_total,
//                                               rsp_is_last, rsp_overflowed
// csr_       in         csr_we                  csr_index, csr_wdata
//
// An add into an empty or a full store is handled at once; else the store is kept sorted
// by shifting each stored track the new one moves past up one entry, one entry per cycle,
// through the RAM's write port and registered read port. A run counts the entries below and
// at the head, takes a setup step, then for each stored visit does a RAM read, then a compare
// and emit; it also emits the end track, turns at the sweep end and finishes.
// Synchronous reset empties the store at once through its fill count; no clearing pass.
// A stalled rsp_ready holds the emit sequence; requests are taken only while no add or run
// is in progress.
module scan_disk_scheduler_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [sdsched_pkg::TRACK_W-1:0]        req_track,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sdsched_pkg::TRACK_W-1:0]        rsp_served_track,
   output logic [sdsched_pkg::SEEK_W-1:0]         rsp_seek_total,
   output logic                                   rsp_is_last,
   output logic                                   rsp_overflowed,
   input  logic                                   csr_we,
   input  logic [sdsched_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sdsched_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = sdsched_pkg::ADDR_W;
   localparam int CW = sdsched_pkg::CNT_W;
   localparam int VW = sdsched_pkg::VIS_W;
   localparam int TW = sdsched_pkg::TRACK_W;
   localparam int SW = sdsched_pkg::SEEK_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(sdsched_pkg::MAX_REQUESTS);

   // Configuration registers
   logic [TW-1:0]                  start_head_ff;
   logic                           sweep_right_ff;
   logic [sdsched_pkg::DISK_W-1:0] disk_tracks_ff;

   // Request store
   logic [TW-1:0] store_mem [sdsched_pkg::MAX_REQUESTS];
   logic [TW-1:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [TW-1:0] mem_wdata;

   // Control state
   sdsched_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [TW-1:0] key_ff, key_in;
   logic [AW-1:0] hole_ff, hole_in;
   logic [CW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0] nlo_ff, nlo_in;
   logic [CW-1:0] nle_ff, nle_in;
   logic          seg_ff, seg_in;
   logic          asc_ff, asc_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] len_ff, len_in;
   logic [TW-1:0] ext_ff, ext_in;
   logic          ext_pend_ff, ext_pend_in;
   logic          ext_read_ff, ext_read_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [TW-1:0] pos_ff, pos_in;
   logic [SW-1:0] seek_ff, seek_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_track_ff, rsp_track_in;
   logic [SW-1:0] rsp_seek_ff, rsp_seek_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          req_fire;
   logic          out_free;
   logic          load_out;
   logic [TW-1:0] load_val;
   logic [TW-1:0] end_track;
   logic [TW-1:0] step_dist;
   logic [SW:0]   seek_sum;
   logic          take_ext;

   assign req_ready = (state_ff == sdsched_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_served_track = rsp_track_ff;
   assign rsp_seek_total   = rsp_seek_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   // Right end track, with disk size clamped to 1..65536
   always_comb begin
      if (disk_tracks_ff == '0) begin
         end_track = '0;
      end else if (disk_tracks_ff[sdsched_pkg::DISK_W-1] &&
                   (disk_tracks_ff[sdsched_pkg::DISK_W-2:0] != '0)) begin
         end_track = '1;
      end else begin
         end_track = TW'(disk_tracks_ff - 1'b1);
      end
   end

   // Seek step toward the value being emitted, saturating
   assign step_dist = (load_val > pos_ff) ? (load_val - pos_ff) : (pos_ff - load_val);
   assign seek_sum  = {1'b0, seek_ff} + {{(SW + 1 - TW){1'b0}}, step_dist};

   // End track goes out ahead of the stored entry when it sorts before it
   assign take_ext = !seg_ff && ext_pend_ff &&
                     (asc_ff ? (ext_ff < rdata_ff) : (rdata_ff < ext_ff));

   // Main sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      hole_in     = hole_ff;
      scan_ptr_in = scan_ptr_ff;
      nlo_in      = nlo_ff;
      nle_in      = nle_ff;
      seg_in      = seg_ff;
      asc_in      = asc_ff;
      ptr_in      = ptr_ff;
      len_in      = len_ff;
      ext_in      = ext_ff;
      ext_pend_in = ext_pend_ff;
      ext_read_in = ext_read_ff;
      rem_in      = rem_ff;
      raddr       = ptr_ff;
      mem_we      = 1'b0;
      mem_waddr   = hole_ff;
      mem_wdata   = key_ff;
      load_out    = 1'b0;
      load_val    = rdata_ff;

      case (state_ff)
         sdsched_pkg::ST_IDLE: begin
            if (req_fire && (req_type == sdsched_pkg::REQ_ADD)) begin
               if (count_ff == MAX_CNT) begin
                  ovf_in = 1'b1;
               end else if (count_ff == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = req_track;
                  count_in  = count_ff + 1'b1;
               end else begin
                  key_in   = req_track;
                  hole_in  = AW'(count_ff);
                  raddr    = AW'(count_ff - 1'b1);
                  state_in = sdsched_pkg::ST_INS;
               end
            end else if (req_fire) begin
               nlo_in = '0;
               nle_in = '0;
               if (count_ff == '0) begin
                  state_in = sdsched_pkg::ST_SETUP;
               end else begin
                  raddr       = '0;
                  scan_ptr_in = CW'(1);
                  state_in    = sdsched_pkg::ST_SCAN;
               end
            end
         end

         // rdata holds the entry just below the hole
         sdsched_pkg::ST_INS: begin
            mem_we = 1'b1;
            if (rdata_ff > key_ff) begin
               mem_wdata = rdata_ff;
               hole_in   = hole_ff - 1'b1;
               if (hole_ff == AW'(1)) begin
                  state_in = sdsched_pkg::ST_INS_PUT;
               end else begin
                  raddr = hole_ff - AW'(2);
               end
            end else begin
               count_in = count_ff + 1'b1;
               state_in = sdsched_pkg::ST_IDLE;
            end
         end

         sdsched_pkg::ST_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_in  = count_ff + 1'b1;
            state_in  = sdsched_pkg::ST_IDLE;
         end

         // Count entries below and at the head
         sdsched_pkg::ST_SCAN: begin
            if (rdata_ff < start_head_ff) begin
               nlo_in = nlo_ff + 1'b1;
            end
            if (rdata_ff <= start_head_ff) begin
               nle_in = nle_ff + 1'b1;
            end
            if (scan_ptr_ff < count_ff) begin
               raddr       = AW'(scan_ptr_ff);
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end else begin
               state_in = sdsched_pkg::ST_SETUP;
            end
         end

         // First sweep leg, end track pending
         sdsched_pkg::ST_SETUP: begin
            seg_in      = 1'b0;
            ext_pend_in = 1'b1;
            ext_read_in = 1'b0;
            rem_in      = VW'(count_ff - (nle_ff - nlo_ff)) + 1'b1;
            if (sweep_right_ff) begin
               asc_in = 1'b1;
               ptr_in = AW'(nle_ff);
               len_in = count_ff - nle_ff;
               ext_in = end_track;
            end else begin
               asc_in = 1'b0;
               ptr_in = AW'(nlo_ff - 1'b1);
               len_in = nlo_ff;
               ext_in = '0;
            end
            state_in = sdsched_pkg::ST_EMIT;
         end

         // ext_read_ff marks that rdata holds the entry at ptr
         sdsched_pkg::ST_EMIT: begin
            if (len_ff == '0) begin
               if (!seg_ff && ext_pend_ff) begin
                  if (out_free) begin
                     load_out    = 1'b1;
                     load_val    = ext_ff;
                     ext_pend_in = 1'b0;
                  end
               end else if (!seg_ff) begin
                  seg_in      = 1'b1;
                  asc_in      = !asc_ff;
                  ext_read_in = 1'b0;
                  if (sweep_right_ff) begin
                     ptr_in = AW'(nlo_ff - 1'b1);
                     len_in = nlo_ff;
                  end else begin
                     ptr_in = AW'(nle_ff);
                     len_in = count_ff - nle_ff;
                  end
               end else begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = sdsched_pkg::ST_IDLE;
               end
            end else if (!ext_read_ff) begin
               ext_read_in = 1'b1;
            end else if (out_free) begin
               load_out = 1'b1;
               if (take_ext) begin
                  load_val    = ext_ff;
                  ext_pend_in = 1'b0;
               end else begin
                  len_in      = len_ff - 1'b1;
                  ptr_in      = asc_ff ? (ptr_ff + 1'b1) : (ptr_ff - 1'b1);
                  ext_read_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = sdsched_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register and running seek
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_track_in = rsp_track_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pos_in       = pos_ff;
      seek_in      = seek_ff;
      if (state_ff == sdsched_pkg::ST_SETUP) begin
         pos_in  = start_head_ff;
         seek_in = '0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_track_in = load_val;
         rsp_seek_in  = seek_sum[SW] ? '1 : seek_sum[SW-1:0];
         rsp_last_in  = (rem_ff == VW'(1));
         rsp_ovf_in   = ovf_ff;
         pos_in       = load_val;
         seek_in      = seek_sum[SW] ? '1 : seek_sum[SW-1:0];
      end
   end

   // Store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_mem[raddr];
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sdsched_pkg::ST_IDLE;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         start_head_ff  <= '0;
         sweep_right_ff <= 1'b0;
         disk_tracks_ff <= 17'h10000;
         ext_pend_ff    <= 1'b0;
         ext_read_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         ext_pend_ff  <= ext_pend_in;
         ext_read_ff  <= ext_read_in;
         if (csr_we) begin
            case (csr_index)
               sdsched_pkg::CSR_START_HEAD:  start_head_ff  <= csr_wdata[TW-1:0];
               sdsched_pkg::CSR_SWEEP_RIGHT: sweep_right_ff <= csr_wdata[0];
               sdsched_pkg::CSR_DISK_TRACKS: disk_tracks_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      hole_ff      <= hole_in;
      scan_ptr_ff  <= scan_ptr_in;
      nlo_ff       <= nlo_in;
      nle_ff       <= nle_in;
      seg_ff       <= seg_in;
      asc_ff       <= asc_in;
      ptr_ff       <= ptr_in;
      len_ff       <= len_in;
      ext_ff       <= ext_in;
      rem_ff       <= load_out ? (rem_in - 1'b1) : rem_in;
      pos_ff       <= pos_in;
      seek_ff      <= seek_in;
      rsp_track_ff <= rsp_track_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule
